// ----- src/depq_pkg.sv -----
package depq_pkg;

    localparam int DEPTH         = 16;
    localparam int COUNT_W       = $clog2(DEPTH + 1);
    localparam int ENTRY_COUNT_W = 5;

    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT  = 2'd0;
    localparam op_t OP_DEL_MIN = 2'd1;
    localparam op_t OP_DEL_MAX = 2'd2;
    localparam op_t OP_QUERY   = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] priority_req;
        logic        [31:0] payload;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [31:0]         removed_priority;
        logic        [31:0]         removed_payload;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
        logic signed [31:0]         min_priority;
        logic        [31:0]         min_payload;
        logic signed [31:0]         max_priority;
        logic        [31:0]         max_payload;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;  // latch the request
        logic    exec;     // operation step
        logic    allow;    // operation changes the store
        logic    load;     // load the result register
        status_t status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

// ----- src/depq_ctrl.sv -----
module depq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  depq_pkg::dp_stat_t stat,
    output depq_pkg::dp_cmd_t  cmd
);
    import depq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // status code of the pending item, held from EXEC to LOAD
    status_t status_reg, status_next;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.status   = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                priority case (1'b1)
                    (stat.op == OP_INSERT) && stat.full:    cmd.allow = 1'b0;
                    (stat.op == OP_DEL_MIN) && stat.empty:  cmd.allow = 1'b0;
                    (stat.op == OP_DEL_MAX) && stat.empty:  cmd.allow = 1'b0;
                    stat.op == OP_QUERY:                    cmd.allow = 1'b0;
                    default:                                cmd.allow = 1'b1;
                endcase
                state_next = S_LOAD;
            end
            S_LOAD: begin
                // the status was decided on the store before the update
                if (out_free) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        status_next = status_reg;
        if (state_reg == S_EXEC) begin
            priority if ((stat.op == OP_INSERT) && stat.full) begin
                status_next = STATUS_FULL;
            end else if ((stat.op == OP_DEL_MIN || stat.op == OP_DEL_MAX) && stat.empty) begin
                status_next = STATUS_EMPTY;
            end else begin
                status_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

endmodule

// ----- src/depq_datapath.sv -----
module depq_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  depq_pkg::req_t    s_data,
    input  depq_pkg::dp_cmd_t cmd,
    output depq_pkg::dp_stat_t stat,
    output depq_pkg::rsp_t    m_data
);
    import depq_pkg::*;

    req_t               req_reg;
    logic signed [31:0] key_reg  [DEPTH];
    logic        [31:0] pay_reg  [DEPTH];
    logic signed [31:0] key_next [DEPTH];
    logic        [31:0] pay_next [DEPTH];
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic signed [31:0] rem_key_reg, rem_key_next;
    logic        [31:0] rem_pay_reg, rem_pay_next;
    rsp_t               rsp_reg;

    logic [DEPTH-1:0]   stay;       // cell keeps its entry on insert
    logic [DEPTH-1:0]   prev_stay;
    logic [DEPTH-1:0]   tail;
    logic signed [31:0] key_below [DEPTH];
    logic        [31:0] pay_below [DEPTH];
    logic signed [31:0] key_above [DEPTH];
    logic        [31:0] pay_above [DEPTH];
    logic signed [31:0] tail_key;
    logic        [31:0] tail_pay;

    assign stat.op    = req_reg.op;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == COUNT_W'(DEPTH));

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign stay[i] = valid_reg[i] && (key_reg[i] > req_reg.priority_req);
        if (i == 0) begin : g_first
            assign prev_stay[i] = 1'b0;
            assign key_below[i] = key_reg[i];
            assign pay_below[i] = pay_reg[i];
        end else begin : g_rest
            assign prev_stay[i] = stay[i-1];
            assign key_below[i] = key_reg[i-1];
            assign pay_below[i] = pay_reg[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign tail[i]      = valid_reg[i];
            assign key_above[i] = key_reg[i];
            assign pay_above[i] = pay_reg[i];
        end else begin : g_inner
            assign tail[i]      = valid_reg[i] && !valid_reg[i+1];
            assign key_above[i] = key_reg[i+1];
            assign pay_above[i] = pay_reg[i+1];
        end
    end

    // one-hot select of the tail entry, zero when empty
    always_comb begin
        tail_key = '0;
        tail_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_key = tail_key | (tail[i] ? key_reg[i] : 32'sd0);
            tail_pay = tail_pay | (tail[i] ? pay_reg[i] : 32'd0);
        end
    end

    always_comb begin
        valid_next   = valid_reg;
        count_next   = count_reg;
        rem_key_next = rem_key_reg;
        rem_pay_next = rem_pay_reg;
        for (int i = 0; i < DEPTH; i++) begin
            key_next[i] = key_reg[i];
            pay_next[i] = pay_reg[i];
        end
        if (cmd.exec) begin
            rem_key_next = '0;
            rem_pay_next = '0;
            if (cmd.allow) begin
                unique case (req_reg.op)
                    OP_INSERT: begin
                        // entries above the new key hold, the rest move one toward the tail
                        for (int i = 0; i < DEPTH; i++) begin
                            if (stay[i]) begin
                                key_next[i] = key_reg[i];
                                pay_next[i] = pay_reg[i];
                            end else if (i == 0 || prev_stay[i]) begin
                                key_next[i] = req_reg.priority_req;
                                pay_next[i] = req_reg.payload;
                            end else begin
                                key_next[i] = key_below[i];
                                pay_next[i] = pay_below[i];
                            end
                        end
                        valid_next = valid_reg | {valid_reg[DEPTH-2:0], 1'b1};
                        count_next = count_reg + 1'b1;
                    end
                    OP_DEL_MIN: begin
                        rem_key_next = tail_key;
                        rem_pay_next = tail_pay;
                        valid_next   = valid_reg & ~tail;
                        count_next   = count_reg - 1'b1;
                    end
                    OP_DEL_MAX: begin
                        rem_key_next = key_reg[0];
                        rem_pay_next = pay_reg[0];
                        for (int i = 0; i < DEPTH; i++) begin
                            key_next[i] = key_above[i];
                            pay_next[i] = pay_above[i];
                        end
                        valid_next = {1'b0, valid_reg[DEPTH-1:1]};
                        count_next = count_reg - 1'b1;
                    end
                    default: begin
                        valid_next = valid_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        for (int i = 0; i < DEPTH; i++) begin
            key_reg[i] <= key_next[i];
            pay_reg[i] <= pay_next[i];
        end
        rem_key_reg <= rem_key_next;
        rem_pay_reg <= rem_pay_next;
        if (cmd.load) begin
            rsp_reg.status           <= cmd.status;
            rsp_reg.removed_priority <= rem_key_reg;
            rsp_reg.removed_payload  <= rem_pay_reg;
            rsp_reg.entry_count      <= ENTRY_COUNT_W'(count_reg);
            rsp_reg.min_priority     <= tail_key;
            rsp_reg.min_payload      <= tail_pay;
            rsp_reg.max_priority     <= valid_reg[0] ? key_reg[0] : 32'sd0;
            rsp_reg.max_payload      <= valid_reg[0] ? pay_reg[0] : 32'd0;
        end
    end

    assign m_data = rsp_reg;

endmodule

// ----- src/double_ended_priority_queue.sv -----
// Double-ended priority queue over a sorted row of DEPTH cells, highest
// priority at the head. Insert, delete-min, delete-max and query each return
// one result that shows the status, the removed entry, the count and the
// current min and max. Items are handled one at a time, step by step: the
// accept step in IDLE, the EXEC step in which the cells update in parallel
// (on insert every cell compares against the new key and moves), then the
// LOAD step, which waits while an earlier result is still held and then puts
// the head and the one-hot tail select into the result register. A finished
// result waits in its own register, and the next item is taken while it waits.
module double_ended_priority_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  depq_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output depq_pkg::rsp_t   m_data
);
    import depq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    depq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    depq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_data      (m_data)
    );

endmodule

// ----- src/depq_checker.sv -----
module depq_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input depq_pkg::rsp_t m_data
);
    import depq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= ENTRY_COUNT_W'(DEPTH))
        else $error("entry count above depth");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.entry_count == '0 |->
            m_data.min_priority == '0 && m_data.max_priority == '0 &&
            m_data.min_payload == '0 && m_data.max_payload == '0)
        else $error("empty queue shows an entry");

    a_no_removal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |->
            m_data.removed_priority == '0 && m_data.removed_payload == '0)
        else $error("rejected operation shows a removed entry");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.entry_count != '0 |->
            m_data.min_priority <= m_data.max_priority)
        else $error("min above max");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
